[src/flow_table_packet_statistics_unit_defines.svh]
// Assertion helpers for the flow statistics unit.
`ifndef FLOW_TABLE_PACKET_STATISTICS_UNIT_DEFINES_SVH
`define FLOW_TABLE_PACKET_STATISTICS_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define FTPS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: property failed");

// Antecedent implies consequent in the next cycle.
`define FTPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: property failed");

`endif

[src/ftps_pkg.sv]
package ftps_pkg;
   localparam int FLOW_SLOTS = 1024;
   localparam int SLOT_W = $clog2(FLOW_SLOTS);
   localparam int COUNT_W = $clog2(FLOW_SLOTS + 1);
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [1:0] STATUS_EXISTING = 2'd0;
   localparam logic [1:0] STATUS_NEW = 2'd1;
   localparam logic [1:0] STATUS_DROPPED = 2'd2;
   localparam logic [1:0] CSR_IDLE_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_BULK_LENGTH = 2'd1;
   localparam logic [1:0] CSR_BULK_TIMEOUT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_READ, ST_UPDATE, ST_WRITE, ST_RESPOND
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic search_start;
      logic search_step;
      logic read;
      logic update;
      logic write;
      logic respond;
   } ctrl_cmd_type;

   typedef struct packed {
      logic search_done;
      logic rsp_taken;
   } ctrl_status_type;
endpackage

[src/ftps_controller.sv]
`include "flow_table_packet_statistics_unit_defines.svh"
module ftps_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ftps_pkg::ctrl_status_type status,
   output ftps_pkg::ctrl_cmd_type    cmd
);
   import ftps_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_SEARCH;
         ST_SEARCH:  if (status.search_done) state_in = ST_READ;
         ST_READ:    state_in = ST_UPDATE;
         ST_UPDATE:  state_in = ST_WRITE;
         ST_WRITE:   state_in = ST_RESPOND;
         ST_RESPOND: if (status.rsp_taken) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.capture = req_valid;
            cmd.search_start = req_valid;
         end
         ST_SEARCH:  cmd.search_step = 1'b1;
         ST_READ:    cmd.read = 1'b1;
         ST_UPDATE:  cmd.update = 1'b1;
         ST_WRITE:   cmd.write = 1'b1;
         ST_RESPOND: cmd.respond = 1'b1;
         default:    cmd = '0;
      endcase
   end

   `FTPS_ASSERT_IMP(a_accept_only_idle, clock, reset, !req_stall, state_ff == ST_IDLE)
   `FTPS_ASSERT_NEXT(a_write_then_respond, clock, reset, cmd.write, cmd.respond)
   `FTPS_ASSERT_NEXT(a_read_after_search, clock, reset,
      cmd.search_step && status.search_done, cmd.read)
endmodule

[src/ftps_datapath.sv]
`include "flow_table_packet_statistics_unit_defines.svh"
module ftps_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  ftps_pkg::ctrl_cmd_type     cmd,
   output ftps_pkg::ctrl_status_type  status,
   input  logic                       csr_write,
   input  logic [1:0]                 csr_index,
   input  logic [63:0]                csr_data,
   input  logic [31:0]                req_source_address,
   input  logic [31:0]                req_destination_address,
   input  logic [15:0]                req_source_port,
   input  logic [15:0]                req_destination_port,
   input  logic [7:0]                 req_protocol_number,
   input  logic [15:0]                req_packet_length,
   input  logic [63:0]                req_arrival_time,
   input  logic [7:0]                 req_tcp_flag_bits,
   input  logic [15:0]                req_receive_window,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic [ftps_pkg::SLOT_W-1:0] rsp_flow_index,
   output logic [1:0]                 rsp_lookup_status,
   output logic                       rsp_is_forward,
   output logic [31:0]                rsp_direction_packets,
   output logic [63:0]                rsp_direction_bytes,
   output logic [15:0]                rsp_direction_min_length,
   output logic [15:0]                rsp_direction_max_length,
   output logic [63:0]                rsp_direction_gap,
   output logic [63:0]                rsp_flow_gap,
   output logic [63:0]                rsp_flow_duration,
   output logic [63:0]                rsp_closed_active_time,
   output logic [31:0]                rsp_closed_bulk_bytes
);
   import ftps_pkg::*;

   // record layout: one wide word per slot, read-modify-written once
   typedef struct packed {
      logic [63:0] start;
      logic [63:0] prev_seen;
      logic        active;
      logic [63:0] active_start;
      logic [63:0] active_sum;
      logic [63:0] active_periods;
      logic [63:0] idle_sum;
      logic [63:0] idle_periods;
      logic [31:0] packets;
      logic [63:0] bytes;
      logic [15:0] min_len;
      logic [15:0] max_len;
      logic [15:0] init_win;
      logic [63:0] sq_sum;
      logic [63:0] prev_arrival;
      logic [63:0] gap_sum;
      logic [63:0] gap_min;
      logic [63:0] gap_max;
      logic        in_bulk;
      logic [63:0] bulk_start;
      logic [31:0] bulk_bytes;
      logic [31:0] bulk_packets;
      logic [63:0] bulks_closed;
      logic [9:0][31:0] flag_cnt;
   } record_type;

   logic [63:0] idle_limit_ff;
   logic [15:0] bulk_len_ff;
   logic [31:0] bulk_hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= 64'd30000000;
         bulk_len_ff <= 16'd1000;
         bulk_hold_ff <= 32'd1000000;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IDLE_TIMEOUT: idle_limit_ff <= csr_data;
            CSR_BULK_LENGTH:  bulk_len_ff <= csr_data[15:0];
            CSR_BULK_TIMEOUT: bulk_hold_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // captured packet
   logic [31:0] src_ff, dst_ff, ports_ff;
   logic [7:0]  proto_ff, flags_ff;
   logic [15:0] len_ff, win_ff;
   logic [63:0] time_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         src_ff <= req_source_address;
         dst_ff <= req_destination_address;
         ports_ff <= (req_protocol_number == PROTO_TCP || req_protocol_number == PROTO_UDP)
                     ? {req_source_port, req_destination_port} : 32'd0;
         proto_ff <= req_protocol_number;
         len_ff <= req_packet_length;
         time_ff <= req_arrival_time;
         flags_ff <= req_tcp_flag_bits;
         win_ff <= req_receive_window;
      end
   end

   // key memory, walked one slot per cycle
   logic [103:0] key_mem [FLOW_SLOTS];
   logic [103:0] key_rd_ff;
   logic [COUNT_W-1:0] used_ff;
   logic [COUNT_W-1:0] scan_ff;      // address presented to key memory
   logic               rd_ok_ff;     // key_rd_ff holds slot scan_ff-1
   logic               found_ff, miss_ff, full_ff;
   logic [SLOT_W-1:0]  idx_ff;
   logic [103:0]       key_cmp;

   assign key_cmp = {src_ff, dst_ff, ports_ff, proto_ff};

   logic hit_now, end_now;
   logic [COUNT_W-1:0] rd_slot;
   assign rd_slot = scan_ff - 1'b1;
   assign hit_now = rd_ok_ff && key_rd_ff == key_cmp;
   assign end_now = !hit_now && scan_ff >= used_ff;
   assign status.search_done = cmd.search_step && (hit_now || end_now);

   always_ff @(posedge clock) begin
      if (scan_ff < COUNT_W'(FLOW_SLOTS)) key_rd_ff <= key_mem[scan_ff[SLOT_W-1:0]];
      if (cmd.write && miss_ff && !full_ff) key_mem[idx_ff] <= key_cmp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         scan_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (cmd.search_start) begin
            scan_ff <= '0;
            rd_ok_ff <= 1'b0;
         end else if (cmd.search_step) begin
            scan_ff <= scan_ff + 1'b1;
            rd_ok_ff <= scan_ff < used_ff;
         end
         if (cmd.write && miss_ff && !full_ff) used_ff <= used_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (status.search_done) begin
         found_ff <= hit_now;
         miss_ff <= !hit_now;
         full_ff <= !hit_now && used_ff == COUNT_W'(FLOW_SLOTS);
         idx_ff <= hit_now ? rd_slot[SLOT_W-1:0] : used_ff[SLOT_W-1:0];
      end
   end

   // record memory
   record_type rec_mem [FLOW_SLOTS];
   record_type rec_rd_ff, rec_new_ff;

   always_ff @(posedge clock) begin
      if (cmd.read) rec_rd_ff <= rec_mem[idx_ff];
      if (cmd.write && !full_ff) rec_mem[idx_ff] <= rec_new_ff;
   end

   // update
   record_type r, n;
   logic [63:0] fgap, dgap, cact, cbulk;
   logic [32:0] bsum, bpk;
   logic [31:0] sq;
   always_comb begin
      r = rec_rd_ff;
      if (miss_ff) begin
         r = '0;
         r.start = time_ff;
         r.prev_seen = time_ff;
         r.active = 1'b1;
         r.active_start = time_ff;
      end
      n = r;
      fgap = '0;
      cact = '0;
      cbulk = '0;
      dgap = '0;
      bsum = '0;
      bpk = '0;
      if (!miss_ff) begin
         fgap = time_ff - r.prev_seen;
         if (fgap > idle_limit_ff && r.active) begin
            cact = r.prev_seen - r.active_start;
            n.active_sum = r.active_sum + cact;
            n.active_periods = r.active_periods + 64'd1;
            n.idle_sum = r.idle_sum + fgap;
            n.idle_periods = r.idle_periods + 64'd1;
            n.active = 1'b0;
         end else if (!r.active && fgap <= idle_limit_ff) begin
            n.active_start = time_ff;
            n.active = 1'b1;
         end
      end
      n.prev_seen = time_ff;
      if (!r.in_bulk) begin
         if (len_ff > bulk_len_ff) begin
            n.in_bulk = 1'b1;
            n.bulk_start = time_ff;
            n.bulk_bytes = {16'd0, len_ff};
            n.bulk_packets = 32'd1;
         end
      end else if (time_ff - r.bulk_start <= {32'd0, bulk_hold_ff}) begin
         bsum = {1'b0, r.bulk_bytes} + {17'd0, len_ff};
         bpk = {1'b0, r.bulk_packets} + 33'd1;
         n.bulk_bytes = bsum[32] ? '1 : bsum[31:0];
         n.bulk_packets = bpk[32] ? '1 : bpk[31:0];
      end else begin
         cbulk = {32'd0, r.bulk_bytes};
         n.bulks_closed = r.bulks_closed + 64'd1;
         n.in_bulk = 1'b0;
      end
      if (r.packets == '0) begin
         n.min_len = len_ff;
         n.max_len = len_ff;
         if (proto_ff == PROTO_TCP) n.init_win = win_ff;
      end else begin
         if (len_ff < r.min_len) n.min_len = len_ff;
         if (len_ff > r.max_len) n.max_len = len_ff;
         dgap = time_ff - r.prev_arrival;
         n.gap_sum = r.gap_sum + dgap;
         if (r.packets == 32'd1 || dgap < r.gap_min) n.gap_min = dgap;
         if (r.packets == 32'd1 || dgap > r.gap_max) n.gap_max = dgap;
      end
      if (r.packets != '1) n.packets = r.packets + 32'd1;
      n.bytes = r.bytes + {48'd0, len_ff};
      sq = len_ff * len_ff;
      n.sq_sum = r.sq_sum + {32'd0, sq};
      n.prev_arrival = time_ff;
      if (proto_ff == PROTO_TCP) begin
         for (int i = 0; i < 8; i++)
            if (flags_ff[i] && r.flag_cnt[i] != '1) n.flag_cnt[i] = r.flag_cnt[i] + 32'd1;
         if (flags_ff[3] && r.flag_cnt[8] != '1) n.flag_cnt[8] = r.flag_cnt[8] + 32'd1;
         if (flags_ff[5] && r.flag_cnt[9] != '1) n.flag_cnt[9] = r.flag_cnt[9] + 32'd1;
      end
   end

   logic [63:0] fgap_ff, dgap_ff, cact_ff, cbulk_ff;
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rec_new_ff <= n;
         fgap_ff <= fgap;
         dgap_ff <= dgap;
         cact_ff <= cact;
         cbulk_ff <= cbulk;
      end
   end

   logic dropped;
   assign dropped = full_ff;
   assign rsp_valid = cmd.respond;
   assign status.rsp_taken = cmd.respond && !rsp_stall;
   assign rsp_flow_index = dropped ? '0 : idx_ff;
   assign rsp_lookup_status = dropped ? STATUS_DROPPED : (miss_ff ? STATUS_NEW : STATUS_EXISTING);
   assign rsp_is_forward = !dropped;
   assign rsp_direction_packets = dropped ? '0 : rec_new_ff.packets;
   assign rsp_direction_bytes = dropped ? '0 : rec_new_ff.bytes;
   assign rsp_direction_min_length = dropped ? '0 : rec_new_ff.min_len;
   assign rsp_direction_max_length = dropped ? '0 : rec_new_ff.max_len;
   assign rsp_direction_gap = dropped ? '0 : dgap_ff;
   assign rsp_flow_gap = dropped ? '0 : fgap_ff;
   assign rsp_flow_duration = dropped ? '0 : time_ff - rec_new_ff.start;
   assign rsp_closed_active_time = dropped ? '0 : cact_ff;
   assign rsp_closed_bulk_bytes = dropped ? '0 : cbulk_ff[31:0];

   `FTPS_ASSERT_IMP(a_used_bounded, clock, reset, 1'b1, used_ff <= COUNT_W'(FLOW_SLOTS))
   `FTPS_ASSERT_IMP(a_found_excl, clock, reset, cmd.respond, !(found_ff && miss_ff))
   `FTPS_ASSERT_NEXT(a_fill_grows, clock, reset, cmd.write && miss_ff && !full_ff,
      used_ff == $past(used_ff) + 1'b1)
endmodule

[src/flow_table_packet_statistics_unit.sv]
// Flow metering table: each packet header transaction is matched by exact
// 5-tuple against the stored flows, a walk over the key memory at one slot
// per cycle, then the flow record is read, updated and written back and
// one response transaction is offered. A new packet is accepted only while
// idle, once the previous response has been taken. Flows are appended on a
// miss and a packet is dropped (status 2, other fields zero) when all slots
// are in use. Table entries hold no reset value; only slots below the fill
// count ever take part in a match.
// Configuration writes go to the idle limit (0), the bulk length threshold
// (1) and the bulk hold time (2) and must be issued only while no
// transaction is open.
module flow_table_packet_statistics_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_destination_address,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_destination_port,
   input  logic [7:0]  req_protocol_number,
   input  logic [15:0] req_packet_length,
   input  logic [63:0] req_arrival_time,
   input  logic [7:0]  req_tcp_flag_bits,
   input  logic [15:0] req_receive_window,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [ftps_pkg::SLOT_W-1:0] rsp_flow_index,
   output logic [1:0]  rsp_lookup_status,
   output logic        rsp_is_forward,
   output logic [31:0] rsp_direction_packets,
   output logic [63:0] rsp_direction_bytes,
   output logic [15:0] rsp_direction_min_length,
   output logic [15:0] rsp_direction_max_length,
   output logic [63:0] rsp_direction_gap,
   output logic [63:0] rsp_flow_gap,
   output logic [63:0] rsp_flow_duration,
   output logic [63:0] rsp_closed_active_time,
   output logic [31:0] rsp_closed_bulk_bytes
);
   import ftps_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer: idle, key walk, read, update, write, respond
   ftps_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .status(status), .cmd(cmd)
   );

   // key memory, record memory, update arithmetic and response holding
   ftps_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_source_address(req_source_address),
      .req_destination_address(req_destination_address),
      .req_source_port(req_source_port),
      .req_destination_port(req_destination_port),
      .req_protocol_number(req_protocol_number),
      .req_packet_length(req_packet_length),
      .req_arrival_time(req_arrival_time),
      .req_tcp_flag_bits(req_tcp_flag_bits),
      .req_receive_window(req_receive_window),
      .rsp_stall(rsp_stall), .rsp_valid(rsp_valid),
      .rsp_flow_index(rsp_flow_index),
      .rsp_lookup_status(rsp_lookup_status),
      .rsp_is_forward(rsp_is_forward),
      .rsp_direction_packets(rsp_direction_packets),
      .rsp_direction_bytes(rsp_direction_bytes),
      .rsp_direction_min_length(rsp_direction_min_length),
      .rsp_direction_max_length(rsp_direction_max_length),
      .rsp_direction_gap(rsp_direction_gap),
      .rsp_flow_gap(rsp_flow_gap),
      .rsp_flow_duration(rsp_flow_duration),
      .rsp_closed_active_time(rsp_closed_active_time),
      .rsp_closed_bulk_bytes(rsp_closed_bulk_bytes)
   );
endmodule
